@@ hdl/rc4sc_pkg.sv @@
// rc4sc_pkg: shared types, constants and register codes of the rc4 cipher unit
// used by every module under hdl, no dependencies
package rc4sc_pkg;

    localparam int P_TABLE_DEPTH   = 256;
    localparam int P_IDX_W         = $clog2(P_TABLE_DEPTH);
    localparam int P_BYTE_W        = 8;
    localparam int P_KEY_WORDS     = 4;
    localparam int P_DATA_W        = 64;
    localparam int P_KEY_BYTES     = P_KEY_WORDS * P_DATA_W / P_BYTE_W;
    localparam int P_KEY_W         = P_KEY_BYTES * P_BYTE_W;
    localparam int P_LEN_W         = 6;
    localparam int P_ADDR_W        = 6;
    localparam int P_MAX_KEY_BYTES = 32;
    localparam int P_CNT_W         = 9;
    localparam logic [P_LEN_W-1:0] P_LEN_RESET = 6'd32;

    localparam logic CMD_REKEY = 1'b0;
    localparam logic CMD_CRYPT = 1'b1;

    typedef enum logic [2:0] {
        REG_KEY_WORD0  = 3'd0,
        REG_KEY_WORD1  = 3'd1,
        REG_KEY_WORD2  = 3'd2,
        REG_KEY_WORD3  = 3'd3,
        REG_KEY_LENGTH = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CR1,
        ST_CR2,
        ST_CR3,
        ST_HOLD,
        ST_KS0,
        ST_KS1,
        ST_KS2,
        ST_KS3
    } t_state;

    typedef struct packed {
        logic                cmd;
        logic [P_BYTE_W-1:0] data_in;
        logic                end_in;
    } t_in_req;

    typedef struct packed {
        logic [P_BYTE_W-1:0] data_out;
        logic                end_out;
    } t_out_res;

    typedef struct packed {
        logic [P_KEY_W-1:0] key;
        logic [P_LEN_W-1:0] len;
    } t_key_cfg;

    typedef struct packed {
        logic [P_IDX_W-1:0]  raddr;
        logic                we;
        logic [P_IDX_W-1:0]  waddr;
        logic [P_BYTE_W-1:0] wdata;
        logic                clr;
    } t_mem_req;

endpackage

@@ hdl/rc4sc_perm_mem.sv @@
// rc4sc_perm_mem: 256 x 8 permutation memory, one read and one write port
// entries without a valid bit read as their own address; depends on rc4sc_pkg
module rc4sc_perm_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rc4sc_pkg::t_mem_req          i_req,
    output logic [rc4sc_pkg::P_BYTE_W-1:0] o_rdata
);

    logic [rc4sc_pkg::P_BYTE_W-1:0] r_mem [rc4sc_pkg::P_TABLE_DEPTH];
    logic [rc4sc_pkg::P_TABLE_DEPTH-1:0] r_valid;
    logic [rc4sc_pkg::P_BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    // write-first bypass on an address match
    always_ff @(posedge i_clk) begin
        if (i_req.clr) begin
            r_rdata <= i_req.raddr;
        end else if (i_req.we && (i_req.waddr == i_req.raddr)) begin
            r_rdata <= i_req.wdata;
        end else if (r_valid[i_req.raddr]) begin
            r_rdata <= r_mem[i_req.raddr];
        end else begin
            r_rdata <= i_req.raddr;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rc4sc_cfg_regs.sv @@
// rc4sc_cfg_regs: apb register file holding the key words and key length
// depends on rc4sc_pkg
module rc4sc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rc4sc_pkg::P_ADDR_W-1:0] paddr,
    input  logic [rc4sc_pkg::P_DATA_W-1:0] pwdata,
    output logic [rc4sc_pkg::P_DATA_W-1:0] prdata,
    output logic                           pready,
    output rc4sc_pkg::t_key_cfg            o_key
);

    logic [rc4sc_pkg::P_DATA_W-1:0] r_key0, r_key1, r_key2, r_key3;
    logic [rc4sc_pkg::P_LEN_W-1:0]  r_len;
    rc4sc_pkg::t_reg_idx            reg_idx;
    logic                           wr_en;

    assign reg_idx = rc4sc_pkg::t_reg_idx'(paddr[rc4sc_pkg::P_ADDR_W-1:3]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
            r_len  <= rc4sc_pkg::P_LEN_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                rc4sc_pkg::REG_KEY_WORD0:  r_key0 <= pwdata;
                rc4sc_pkg::REG_KEY_WORD1:  r_key1 <= pwdata;
                rc4sc_pkg::REG_KEY_WORD2:  r_key2 <= pwdata;
                rc4sc_pkg::REG_KEY_WORD3:  r_key3 <= pwdata;
                rc4sc_pkg::REG_KEY_LENGTH: r_len  <= pwdata[rc4sc_pkg::P_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rc4sc_pkg::REG_KEY_WORD0:  prdata = r_key0;
            rc4sc_pkg::REG_KEY_WORD1:  prdata = r_key1;
            rc4sc_pkg::REG_KEY_WORD2:  prdata = r_key2;
            rc4sc_pkg::REG_KEY_WORD3:  prdata = r_key3;
            rc4sc_pkg::REG_KEY_LENGTH: prdata = rc4sc_pkg::P_DATA_W'(r_len);
            default:                   prdata = '0;
        endcase
    end

    assign o_key.key = {r_key3, r_key2, r_key1, r_key0};
    assign o_key.len = r_len;

endmodule

@@ hdl/rc4sc_engine.sv @@
// rc4sc_engine: sequencer for key schedule and keystream, drives the table memory
// holds both indices and the result register; depends on rc4sc_pkg
module rc4sc_engine #(
    parameter int MAX_KEY_BYTES = rc4sc_pkg::P_MAX_KEY_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  rc4sc_pkg::t_in_req               i_in_req,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output rc4sc_pkg::t_out_res              o_out_res,
    input  rc4sc_pkg::t_key_cfg              i_key,
    output rc4sc_pkg::t_mem_req              o_mem_req,
    input  logic [rc4sc_pkg::P_BYTE_W-1:0]   i_mem_rdata
);

    localparam int KP_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KB_W = $clog2(rc4sc_pkg::P_KEY_BYTES);
    localparam int IW   = rc4sc_pkg::P_IDX_W;
    localparam int BW   = rc4sc_pkg::P_BYTE_W;
    localparam int CW   = rc4sc_pkg::P_CNT_W;

    rc4sc_pkg::t_state   r_state, n_state;
    logic [IW-1:0]       r_idx_a, n_idx_a;
    logic [IW-1:0]       r_idx_b, n_idx_b;
    logic                r_out_valid, n_out_valid;
    rc4sc_pkg::t_out_res r_out_res, n_out_res;
    rc4sc_pkg::t_out_res r_hold, n_hold;
    logic [BW-1:0]       r_data, n_data;
    logic                r_end, n_end;
    logic [BW-1:0]       r_si, n_si;
    logic [IW-1:0]       r_kaddr, n_kaddr;
    logic [IW-1:0]       r_k, n_k;
    logic [IW-1:0]       r_m, n_m;
    logic [KP_W-1:0]     r_kp, n_kp;

    logic                out_free;
    logic                in_take;
    logic [CW-1:0]       len_ext;
    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       kpos;
    logic [BW-1:0]       key_byte;
    logic [BW-1:0]       ks;
    rc4sc_pkg::t_out_res res;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == rc4sc_pkg::ST_IDLE) ||
                           ((r_state == rc4sc_pkg::ST_CR3) && out_free));
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // effective key length, zero taken as one, saturated to the maximum
    always_comb begin
        len_ext = CW'(i_key.len);
        if (len_ext == '0) begin
            n_eff = CW'(1);
        end else if (len_ext > CW'(MAX_KEY_BYTES)) begin
            n_eff = CW'(MAX_KEY_BYTES);
        end else begin
            n_eff = len_ext;
        end
    end

    assign kpos     = CW'(r_kp);
    assign key_byte = (kpos < CW'(rc4sc_pkg::P_KEY_BYTES)) ?
                      i_key.key[{kpos[KB_W-1:0], 3'b000} +: BW] : '0;

    assign ks           = (r_kaddr == r_idx_b) ? r_si : i_mem_rdata;
    assign res.data_out = r_data ^ ks;
    assign res.end_out  = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc4sc_pkg::ST_IDLE;
            r_idx_a     <= '0;
            r_idx_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx_a     <= n_idx_a;
            r_idx_b     <= n_idx_b;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_res <= n_out_res;
        r_hold    <= n_hold;
        r_data    <= n_data;
        r_end     <= n_end;
        r_si      <= n_si;
        r_kaddr   <= n_kaddr;
        r_k       <= n_k;
        r_m       <= n_m;
        r_kp      <= n_kp;
    end

    always_comb begin
        n_state     = r_state;
        n_idx_a     = r_idx_a;
        n_idx_b     = r_idx_b;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_res   = r_out_res;
        n_hold      = r_hold;
        n_data      = r_data;
        n_end       = r_end;
        n_si        = r_si;
        n_kaddr     = r_kaddr;
        n_k         = r_k;
        n_m         = r_m;
        n_kp        = r_kp;
        o_mem_req   = '0;

        case (r_state)
            rc4sc_pkg::ST_CR1: begin
                n_si            = i_mem_rdata;
                n_idx_b         = r_idx_b + i_mem_rdata;
                o_mem_req.raddr = r_idx_b + i_mem_rdata;
                n_state         = rc4sc_pkg::ST_CR2;
            end
            rc4sc_pkg::ST_CR2: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_idx_a;
                o_mem_req.wdata = i_mem_rdata;
                n_kaddr         = r_si + i_mem_rdata;
                o_mem_req.raddr = r_si + i_mem_rdata;
                n_state         = rc4sc_pkg::ST_CR3;
            end
            rc4sc_pkg::ST_CR3: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_idx_b;
                o_mem_req.wdata = r_si;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_res   = res;
                    n_state     = rc4sc_pkg::ST_IDLE;
                end else begin
                    n_hold  = res;
                    n_state = rc4sc_pkg::ST_HOLD;
                end
            end
            rc4sc_pkg::ST_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_hold;
                    n_state     = rc4sc_pkg::ST_IDLE;
                end
            end
            rc4sc_pkg::ST_KS0: begin
                o_mem_req.clr   = 1'b1;
                o_mem_req.raddr = '0;
                n_k             = '0;
                n_m             = '0;
                n_kp            = '0;
                n_idx_a         = '0;
                n_idx_b         = '0;
                n_state         = rc4sc_pkg::ST_KS1;
            end
            rc4sc_pkg::ST_KS1: begin
                n_si            = i_mem_rdata;
                n_m             = r_m + i_mem_rdata + key_byte;
                o_mem_req.raddr = r_m + i_mem_rdata + key_byte;
                n_state         = rc4sc_pkg::ST_KS2;
            end
            rc4sc_pkg::ST_KS2: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_k;
                o_mem_req.wdata = i_mem_rdata;
                n_state         = rc4sc_pkg::ST_KS3;
            end
            rc4sc_pkg::ST_KS3: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_m;
                o_mem_req.wdata = r_si;
                if (r_k == IW'(rc4sc_pkg::P_TABLE_DEPTH - 1)) begin
                    n_state = rc4sc_pkg::ST_IDLE;
                end else begin
                    n_k             = r_k + 1'b1;
                    o_mem_req.raddr = r_k + 1'b1;
                    if (kpos + CW'(1) == n_eff) begin
                        n_kp = '0;
                    end else begin
                        n_kp = r_kp + 1'b1;
                    end
                    n_state = rc4sc_pkg::ST_KS1;
                end
            end
            default: ;
        endcase

        // new request, taken in idle or while the previous byte finishes with the result free
        if (in_take) begin
            if (i_in_req.cmd == rc4sc_pkg::CMD_CRYPT) begin
                n_idx_a         = r_idx_a + 1'b1;
                o_mem_req.raddr = r_idx_a + 1'b1;
                n_data          = i_in_req.data_in;
                n_end           = i_in_req.end_in;
                n_state         = rc4sc_pkg::ST_CR1;
            end else begin
                n_state = rc4sc_pkg::ST_KS0;
            end
        end
    end

endmodule

@@ hdl/rc4_stream_cipher_unit.sv @@
// rc4_stream_cipher_unit: top level, a crypt byte passes engine states cr1, cr2, cr3
// and the next request is taken in cr3 if the result is free, a pace set by the single
// table read port; a rekey request keeps the unit busy while it clears and swaps
// each entry; synchronous active-low reset: table reads as identity, both indices zero,
// key words zero, key length 32; depends on rc4sc_pkg and the rc4sc modules
module rc4_stream_cipher_unit #(
    parameter int MAX_KEY_BYTES = rc4sc_pkg::P_MAX_KEY_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rc4sc_pkg::t_in_req             i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rc4sc_pkg::t_out_res            o_out_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rc4sc_pkg::P_ADDR_W-1:0] paddr,
    input  logic [rc4sc_pkg::P_DATA_W-1:0] pwdata,
    output logic [rc4sc_pkg::P_DATA_W-1:0] prdata,
    output logic                           pready
);

    rc4sc_pkg::t_key_cfg            key_cfg;
    rc4sc_pkg::t_mem_req            mem_req;
    logic [rc4sc_pkg::P_BYTE_W-1:0] mem_rdata;

    rc4sc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (key_cfg)
    );

    rc4sc_perm_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    rc4sc_engine #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_eng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .i_key       (key_cfg),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

endmodule

@@ hdl/rc4sc_checker.sv @@
// rc4sc_checker: port-level assertions for rc4_stream_cipher_unit, bound to the top
// depends on rc4sc_pkg
module rc4sc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  rc4sc_pkg::t_in_req             i_in_req,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  rc4sc_pkg::t_out_res            o_out_res,
    input  logic                           psel,
    input  logic                           pwrite,
    input  logic [rc4sc_pkg::P_ADDR_W-1:0] paddr,
    input  logic [rc4sc_pkg::P_DATA_W-1:0] prdata
);

    logic in_take;
    assign in_take = i_in_valid && !o_in_stall;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("result changed under stall");

    // one request at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("request taken while busy");

    // key schedule makes no result
    a_rekey_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && (i_in_req.cmd == rc4sc_pkg::CMD_REKEY) |=> ##1 !$rose(o_out_valid))
        else $error("result from key schedule");

    // key length reads back six bits only
    a_len_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite && (paddr[rc4sc_pkg::P_ADDR_W-1:3] == rc4sc_pkg::REG_KEY_LENGTH)
        |-> (prdata[rc4sc_pkg::P_DATA_W-1:rc4sc_pkg::P_LEN_W] == '0))
        else $error("key length read has upper bits set");

endmodule

bind rc4_stream_cipher_unit rc4sc_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res),
    .psel        (psel),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .prdata      (prdata)
);

@@ test/rc4_checker.sv @@
// rc4_checker: watches the request, result and register ports of the rc4 cipher unit,
// predicts every output byte with its own copy of the permutation and key, compares them
// depends on rc4sc_pkg for the request, result and register types
module rc4_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  rc4sc_pkg::t_in_req             i_in_req,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  rc4sc_pkg::t_out_res            i_out_res,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [rc4sc_pkg::P_ADDR_W-1:0] i_paddr,
    input  logic [rc4sc_pkg::P_DATA_W-1:0] i_pwdata,
    output int                             o_fail_count,
    output int                             o_pending
);

    logic [rc4sc_pkg::P_BYTE_W-1:0] sbox [rc4sc_pkg::P_TABLE_DEPTH];
    logic [rc4sc_pkg::P_IDX_W-1:0]  idx_i;
    logic [rc4sc_pkg::P_IDX_W-1:0]  idx_j;
    logic [rc4sc_pkg::P_DATA_W-1:0] key_reg [rc4sc_pkg::P_KEY_WORDS];
    logic [rc4sc_pkg::P_LEN_W-1:0]  key_len_reg;
    rc4sc_pkg::t_out_res            expected_bytes_q [$];
    rc4sc_pkg::t_out_res            want;
    int                             fail_total = 0;

    function automatic logic [rc4sc_pkg::P_BYTE_W-1:0] key_byte_at(int pos);
        if (pos >= rc4sc_pkg::P_KEY_WORDS * 8) begin
            return '0;
        end
        return key_reg[pos >> 3][(pos & 7) * 8 +: 8];
    endfunction

    function automatic void load_identity();
        for (int k = 0; k < rc4sc_pkg::P_TABLE_DEPTH; k++) begin
            sbox[k] = k[rc4sc_pkg::P_BYTE_W-1:0];
        end
    endfunction

    function automatic void rebuild_table();
        int n;
        int m;
        logic [rc4sc_pkg::P_BYTE_W-1:0] swap;
        n = int'(key_len_reg);
        if (n == 0) begin
            n = 1;
        end
        if (n > rc4sc_pkg::P_MAX_KEY_BYTES) begin
            n = rc4sc_pkg::P_MAX_KEY_BYTES;
        end
        load_identity();
        m = 0;
        for (int k = 0; k < rc4sc_pkg::P_TABLE_DEPTH; k++) begin
            m = (m + sbox[k] + key_byte_at(k % n)) % rc4sc_pkg::P_TABLE_DEPTH;
            swap = sbox[k];
            sbox[k] = sbox[m];
            sbox[m] = swap;
        end
        idx_i = '0;
        idx_j = '0;
    endfunction

    function automatic rc4sc_pkg::t_out_res crypt_byte(rc4sc_pkg::t_in_req req);
        logic [rc4sc_pkg::P_BYTE_W-1:0] swap;
        logic [rc4sc_pkg::P_IDX_W-1:0]  ks_idx;
        rc4sc_pkg::t_out_res            res;
        idx_i = idx_i + 1'b1;
        idx_j = idx_j + sbox[idx_i];
        swap = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = swap;
        ks_idx = sbox[idx_i] + sbox[idx_j];
        res.data_out = req.data_in ^ sbox[ks_idx];
        res.end_out = req.end_in;
        return res;
    endfunction

    function automatic void write_reg(logic [rc4sc_pkg::P_ADDR_W-1:0] addr,
                                      logic [rc4sc_pkg::P_DATA_W-1:0] data);
        case (rc4sc_pkg::t_reg_idx'(addr[5:3]))
            rc4sc_pkg::REG_KEY_WORD0, rc4sc_pkg::REG_KEY_WORD1,
            rc4sc_pkg::REG_KEY_WORD2, rc4sc_pkg::REG_KEY_WORD3: begin
                key_reg[addr[4:3]] = data;
            end
            rc4sc_pkg::REG_KEY_LENGTH: begin
                key_len_reg = data[rc4sc_pkg::P_LEN_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rc4sc_pkg::P_KEY_WORDS; k++) begin
                key_reg[k] = '0;
            end
            key_len_reg = rc4sc_pkg::P_LEN_RESET;
            load_identity();
            idx_i = '0;
            idx_j = '0;
            expected_bytes_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                write_reg(i_paddr, i_pwdata);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes_q.size() == 0) begin
                    $error("unexpected result: data_out %02h end_out %0b",
                           i_out_res.data_out, i_out_res.end_out);
                    fail_total++;
                end else begin
                    want = expected_bytes_q.pop_front();
                    if (i_out_res.data_out !== want.data_out) begin
                        $error("data_out mismatch: expected %02h, actual %02h",
                               want.data_out, i_out_res.data_out);
                        fail_total++;
                    end
                    if (i_out_res.end_out !== want.end_out) begin
                        $error("end_out mismatch: expected %0b, actual %0b",
                               want.end_out, i_out_res.end_out);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_req.cmd == rc4sc_pkg::CMD_REKEY) begin
                    rebuild_table();
                end else begin
                    expected_bytes_q.push_back(crypt_byte(i_in_req));
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_bytes_q.size();
    end

endmodule

@@ test/tb_top.sv @@
// tb_top: drives requests, register writes and output back-pressure into the rc4 cipher unit
// and gives the verdict from rc4_checker's failure and pending counts; depends on rc4sc_pkg
module tb_top;

    localparam int          SETTLE_CYCLES = 800;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 125;
    localparam logic [2:0]  REG_HOLE      = 3'd5;
    localparam logic [2:0]  REG_TOP       = 3'd7;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           in_valid = 1'b0;
    rc4sc_pkg::t_in_req             in_req   = '0;
    logic                           out_stall = 1'b0;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [rc4sc_pkg::P_ADDR_W-1:0] paddr    = '0;
    logic [rc4sc_pkg::P_DATA_W-1:0] pwdata   = '0;
    logic                           in_stall;
    logic                           out_valid;
    rc4sc_pkg::t_out_res            out_res;
    logic [rc4sc_pkg::P_DATA_W-1:0] prdata;
    logic                           pready;
    int                             fail_count;
    int                             pending;
    int                             cycles   = 0;
    int                             tx_run   = 0;
    logic                           tx_quiet = 1'b0;
    logic                           rx_quiet = 1'b0;
    logic                           rx_long_hold = 1'b0;

    rc4_stream_cipher_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    rc4_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_res    (out_res),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side back-pressure
    initial begin : rx_side
        int n;
        @(posedge clk);
        forever begin
            if (rx_quiet) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else if (rx_long_hold) begin
                rx_long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                n = $urandom_range(1, 18);
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic tx_pace();
        int n;
        if (tx_quiet) begin
            return;
        end
        if (tx_run > 0) begin
            tx_run--;
        end else if ($urandom_range(0, 1) == 1) begin
            n = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end else begin
            tx_run = $urandom_range(1, 18);
        end
    endtask

    task automatic send_item(input logic cmd, input logic [rc4sc_pkg::P_BYTE_W-1:0] data,
                             input logic eom);
        in_valid <= 1'b1;
        in_req   <= {cmd, data, eom};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tx_pace();
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx,
                             input logic [rc4sc_pkg::P_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [rc4sc_pkg::P_DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic set_key(input logic [rc4sc_pkg::P_DATA_W-1:0] w0,
                           input logic [rc4sc_pkg::P_DATA_W-1:0] w1,
                           input logic [rc4sc_pkg::P_DATA_W-1:0] w2,
                           input logic [rc4sc_pkg::P_DATA_W-1:0] w3,
                           input logic [rc4sc_pkg::P_LEN_W-1:0] len);
        logic [rc4sc_pkg::P_DATA_W-1:0] len_word;
        len_word = rand_word();
        len_word[rc4sc_pkg::P_LEN_W-1:0] = len;
        apb_write(rc4sc_pkg::REG_KEY_WORD0, w0);
        apb_write(rc4sc_pkg::REG_KEY_WORD1, w1);
        apb_write(rc4sc_pkg::REG_KEY_WORD2, w2);
        apb_write(rc4sc_pkg::REG_KEY_WORD3, w3);
        apb_write(rc4sc_pkg::REG_KEY_LENGTH, len_word);
    endtask

    initial begin : tx_side
        int                             r;
        logic [rc4sc_pkg::P_LEN_W-1:0]  len;
        logic [rc4sc_pkg::P_DATA_W-1:0] w0;
        logic [rc4sc_pkg::P_DATA_W-1:0] w1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // crypt on the reset table before any rekey
        send_item(rc4sc_pkg::CMD_CRYPT, 8'h00, 1'b0);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'hFF, 1'b1);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'hA5, 1'b0);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'h5A, 1'b1);
        drain_results();

        // zero key length, treated as one byte
        set_key('0, '1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '0);
        send_item(rc4sc_pkg::CMD_REKEY, 8'h00, 1'b0);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'h00, 1'b0);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'hFF, 1'b0);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'h3C, 1'b1);
        drain_results();

        // oversized key length saturates
        set_key('1, '1, '1, '1, 6'h3F);
        send_item(rc4sc_pkg::CMD_REKEY, 8'hFF, 1'b1);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'hC3, 1'b0);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'h00, 1'b1);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'hFF, 1'b0);
        drain_results();

        set_key('1, '0, '0, '0, 6'd1);
        send_item(rc4sc_pkg::CMD_REKEY, 8'h00, 1'b0);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'h81, 1'b1);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'h7E, 1'b0);
        drain_results();

        // writes to unmapped registers leave the key untouched
        apb_write(REG_HOLE, '1);
        apb_write(REG_TOP, '1);
        set_key(rand_word(), rand_word(), rand_word(), rand_word(), 6'd32);
        send_item(rc4sc_pkg::CMD_REKEY, 8'h00, 1'b0);
        send_item(rc4sc_pkg::CMD_REKEY, 8'h00, 1'b0);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'h55, 1'b0);
        send_item(rc4sc_pkg::CMD_REKEY, 8'h00, 1'b0);
        send_item(rc4sc_pkg::CMD_CRYPT, 8'hAA, 1'b1);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: len = 6'd1;
                1: len = 6'd32;
                2: len = 6'd0;
                3: len = 6'd63;
                4: len = 6'($urandom_range(33, 63));
                default: len = 6'($urandom_range(1, 31));
            endcase
            w0 = (p == 0) ? '0 : (p == 1) ? '1 : rand_word();
            w1 = (p == 1) ? '1 : rand_word();
            if (p % 2 == 1) begin
                apb_write(($urandom_range(0, 1) == 1) ? REG_HOLE : REG_TOP, rand_word());
            end
            set_key(w0, w1, rand_word(), rand_word(), len);
            if (p == PHASES - 1) begin
                rx_quiet = 1'b1;
                tx_quiet = 1'b1;
            end
            send_item(rc4sc_pkg::CMD_REKEY, 8'($urandom_range(0, 255)), 1'b0);
            if (p == 3) begin
                tx_quiet = 1'b1;
                rx_long_hold = 1'b1;
                for (int n = 0; n < 40; n++) begin
                    send_item(rc4sc_pkg::CMD_CRYPT, 8'($urandom_range(0, 255)),
                              $urandom_range(0, 7) == 0);
                end
                tx_quiet = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    send_item(rc4sc_pkg::CMD_REKEY, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_item(rc4sc_pkg::CMD_CRYPT, 8'($urandom_range(0, 255)),
                              $urandom_range(0, 7) == 0);
                end
            end
            drain_results();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/rc4sc_pkg.sv
hdl/rc4sc_perm_mem.sv
hdl/rc4sc_cfg_regs.sv
hdl/rc4sc_engine.sv
hdl/rc4_stream_cipher_unit.sv
hdl/rc4sc_checker.sv
test/rc4_checker.sv
test/tb_top.sv
